// File: src/assert_macros.svh
// assertion helpers used by the checker file
// both expect signals named clk and arst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// property must never hold at a clock edge outside reset
`define ASSERT_NEVER(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) \
		else $error(msg);

`endif

// File: src/oal_pkg.sv
package oal_pkg;

	// list capacity and field widths
	localparam int LIST_DEPTH = 64;
	localparam int ADDR_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMD_W = 2;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int IDX_W = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 2'd0,
		CMD_LOCATE = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic walk;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

// File: src/oal_cmd_if.sv
interface oal_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [oal_pkg::CMD_W-1:0] command;
	logic [oal_pkg::POS_W-1:0] position;
	logic [oal_pkg::VAL_W-1:0] value;

	modport source (output valid, command, position, value, input ready);
	modport sink (input valid, command, position, value, output ready);
endinterface

// File: src/oal_rsp_if.sv
interface oal_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic [oal_pkg::VAL_W-1:0] read_value;
	logic [oal_pkg::IDX_W-1:0] found_index;
	logic [oal_pkg::CNT_W-1:0] element_count;

	modport source (output valid, ok, read_value, found_index, element_count, input ready);
	modport sink (input valid, ok, read_value, found_index, element_count, output ready);
endinterface

// File: src/oal_ram.sv
module oal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// File: src/oal_ctrl.sv
module oal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  oal_pkg::sts_t sts,
	output oal_pkg::ctl_t ctl
);
	import oal_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		ctl.load   = 1'b0;
		ctl.walk   = 1'b0;
		ctl.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_WALK: begin
				ctl.walk = 1'b1;
			end
			ST_FINISH: begin
				ctl.finish = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: src/oal_datapath.sv
module oal_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  oal_pkg::ctl_t             ctl,
	output oal_pkg::sts_t             sts,
	input  logic [oal_pkg::CMD_W-1:0] in_command,
	input  logic [oal_pkg::POS_W-1:0] in_position,
	input  logic [oal_pkg::VAL_W-1:0] in_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_ok,
	output logic [oal_pkg::VAL_W-1:0] out_read_value,
	output logic [oal_pkg::IDX_W-1:0] out_found_index,
	output logic [oal_pkg::CNT_W-1:0] out_element_count
);
	import oal_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

	// command registers
	cmd_t              cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  val_q;
	logic              legal_q;
	logic [CNT_W-1:0]  count_q;

	// walk registers
	logic [ADDR_W-1:0] ptr_q;
	logic [CNT_W-1:0]  rem_q;
	logic              found_q;
	logic [IDX_W-1:0]  fidx_q;
	logic [VAL_W-1:0]  rdv_q;
	logic              rvld_s1;
	logic [ADDR_W-1:0] raddr_s1;

	// output register
	logic              out_valid_q;
	logic              ok_q;
	logic [VAL_W-1:0]  rd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;

	cmd_t              in_cmd;
	logic              in_legal;
	logic [CNT_W-1:0]  rem_init;
	logic [ADDR_W-1:0] ptr_init;
	logic              issue;
	logic              process;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [VAL_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  count_next;

	assign in_cmd = cmd_t'(in_command);

	// legality and walk range of an incoming item
	always_comb begin
		in_legal = 1'b0;
		rem_init = '0;
		ptr_init = '0;
		case (in_cmd)
			CMD_GET: begin
				in_legal = in_position < count_q;
				rem_init = in_legal ? CNT_W'(1) : '0;
				ptr_init = in_position[ADDR_W-1:0];
			end
			CMD_LOCATE: begin
				in_legal = 1'b1;
				rem_init = count_q;
				ptr_init = '0;
			end
			CMD_INSERT: begin
				in_legal = (count_q < DEPTH_C) && (in_position <= count_q);
				rem_init = in_legal ? CNT_W'(count_q - in_position) : '0;
				ptr_init = ADDR_W'(count_q - CNT_W'(1));
			end
			CMD_DELETE: begin
				in_legal = in_position < count_q;
				rem_init = in_legal ? CNT_W'(count_q - in_position - CNT_W'(1)) : '0;
				ptr_init = ADDR_W'(in_position + POS_W'(1));
			end
			default: begin
				in_legal = 1'b0;
			end
		endcase
	end

	// one read issued per walk cycle while reads remain and no match is found, its data handled in the next cycle
	assign issue   = ctl.walk && (rem_q != '0) && !found_q;
	assign process = ctl.walk && rvld_s1;

	// store write: moved element during the walk, new element at finish for a legal insert
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = raddr_s1;
		ram_wdata = ram_rdata;
		if (ctl.finish) begin
			ram_we    = (cmd_q == CMD_INSERT) && legal_q;
			ram_waddr = pos_q[ADDR_W-1:0];
			ram_wdata = val_q;
		end else if (process && cmd_q == CMD_INSERT) begin
			ram_we    = 1'b1;
			ram_waddr = raddr_s1 + ADDR_W'(1);
		end else if (process && cmd_q == CMD_DELETE) begin
			ram_we    = 1'b1;
			ram_waddr = raddr_s1 - ADDR_W'(1);
		end
	end

	oal_ram #(
		.WIDTH(VAL_W),
		.DEPTH(LIST_DEPTH)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr  (ptr_q),
		.rdata_q(ram_rdata)
	);

	// count after the command
	always_comb begin
		count_next = count_q;
		if (legal_q && cmd_q == CMD_INSERT) count_next = count_q + CNT_W'(1);
		if (legal_q && cmd_q == CMD_DELETE) count_next = count_q - CNT_W'(1);
	end

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= in_cmd;
			pos_q   <= in_position;
			val_q   <= in_value;
			legal_q <= in_legal;
		end
	end

	// walk pointer, remaining reads and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			rvld_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			rvld_s1 <= issue;
			if (ctl.load) begin
				rem_q   <= rem_init;
				found_q <= 1'b0;
			end else begin
				if (issue) rem_q <= rem_q - CNT_W'(1);
				if (process && cmd_q == CMD_LOCATE && !found_q && ram_rdata == val_q) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= ptr_q;
		if (ctl.load) begin
			ptr_q <= ptr_init;
		end else if (issue) begin
			ptr_q <= (cmd_q == CMD_INSERT) ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
		end
		if (process && cmd_q == CMD_LOCATE && !found_q) fidx_q <= IDX_W'(raddr_s1);
		if (process && cmd_q == CMD_GET) rdv_q <= ram_rdata;
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.finish) begin
			count_q <= count_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			ok_q  <= (cmd_q == CMD_LOCATE) ? found_q : legal_q;
			rd_q  <= (cmd_q == CMD_GET && legal_q) ? rdv_q : '0;
			idx_q <= (cmd_q == CMD_LOCATE && found_q) ? fidx_q : '0;
			cnt_q <= count_next;
		end
	end

	assign sts.walk_done = ((rem_q == '0) && !rvld_s1) || found_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign out_ok            = ok_q;
	assign out_read_value    = rd_q;
	assign out_found_index   = idx_q;
	assign out_element_count = cnt_q;

endmodule

// File: src/ordered_array_list_engine.sv
// one item at a time: the next item is accepted only after the result of the last one is registered
// the walk reads one element per cycle: one for a get, each moved element for an insert or delete,
// up to the element count for a locate, which stops at the first match; a rejected item reads none
// a result still stalled at the output holds the next item in its finish step
// reset: element count and handshakes cleared, store contents left undefined
module ordered_array_list_engine (
	input logic       clk,
	input logic       arst_n,
	oal_cmd_if.sink   cmd,
	oal_rsp_if.source rsp
);
	import oal_pkg::*;

	ctl_t ctl;
	sts_t sts;

	oal_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmd.valid),
		.in_ready(cmd.ready),
		.sts     (sts),
		.ctl     (ctl)
	);

	oal_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.in_command       (cmd.command),
		.in_position      (cmd.position),
		.in_value         (cmd.value),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_ok           (rsp.ok),
		.out_read_value   (rsp.read_value),
		.out_found_index  (rsp.found_index),
		.out_element_count(rsp.element_count)
	);

endmodule

// File: src/oal_checker.sv
`include "assert_macros.svh"

module oal_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_ok,
	input logic [oal_pkg::VAL_W-1:0] rsp_read_value,
	input logic [oal_pkg::IDX_W-1:0] rsp_found_index,
	input logic [oal_pkg::CNT_W-1:0] rsp_element_count
);
	import oal_pkg::*;

	logic [1:0]       pend_q;
	logic [CNT_W-1:0] prev_cnt_q;
	logic             cmd_hs;
	logic             rsp_hs;

	assign cmd_hs = cmd_valid && cmd_ready;
	assign rsp_hs = rsp_valid && rsp_ready;

	// items taken but not yet answered, and count of the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			prev_cnt_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(cmd_hs) - 2'(rsp_hs);
			if (rsp_hs) prev_cnt_q <= rsp_element_count;
		end
	end

	`ASSERT_ALWAYS(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_count), "result dropped or changed while stalled")
	`ASSERT_NEVER(a_rsp_unasked, rsp_valid && pend_q == 2'd0, "result without an outstanding item")
	`ASSERT_NEVER(a_count_over, rsp_valid && rsp_element_count > CNT_W'(LIST_DEPTH), "element count above capacity")
	`ASSERT_NEVER(a_fields_zero, rsp_valid && !rsp_ok && (rsp_read_value != '0 || rsp_found_index != '0), "unused result fields not zero")
	`ASSERT_ALWAYS(a_count_step, rsp_valid |-> (rsp_element_count == prev_cnt_q) || (rsp_element_count == prev_cnt_q + CNT_W'(1)) || (rsp_element_count + CNT_W'(1) == prev_cnt_q), "count moved by more than one")

endmodule

bind ordered_array_list_engine oal_checker u_oal_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_ok           (rsp.ok),
	.rsp_read_value   (rsp.read_value),
	.rsp_found_index  (rsp.found_index),
	.rsp_element_count(rsp.element_count)
);

// File: sim/tb_top.sv
module tb_top;
	import oal_pkg::*;

	localparam int ITEM_TARGET  = 1800;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

	typedef struct {
		cmd_t             command;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} list_cmd_t;

	typedef struct {
		logic             ok;
		logic [VAL_W-1:0] read_value;
		logic [IDX_W-1:0] found_index;
		logic [CNT_W-1:0] element_count;
	} list_result_t;

	logic clk;
	logic arst_n;

	oal_cmd_if cmd_bus ();
	oal_rsp_if rsp_bus ();

	ordered_array_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// commands waiting to be driven and results still owed by the block
	list_cmd_t    pending_cmds[$];
	list_result_t owed_results[$];

	// predicted list contents and length
	logic [VAL_W-1:0] list_mem [LIST_DEPTH];
	int               list_len = 0;

	// planning copy of the list, only used to shape the stimulus
	logic [VAL_W-1:0] plan_list[$];

	int        item_total = 0;
	int        cmd_taken = 0;
	int        errors = 0;
	int        quiet_cycles = 0;
	int        tx_idle_pct;
	int        rx_idle_pct;
	list_cmd_t next_cmd;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one command to the predicted list and build its result
	function automatic list_result_t apply_list_command(list_cmd_t c);
		list_result_t r;
		int           p;
		r.ok = 1'b0;
		r.read_value = '0;
		r.found_index = '0;
		p = int'(c.position);
		case (c.command)
			CMD_GET: begin
				if (p < list_len) begin
					r.ok = 1'b1;
					r.read_value = list_mem[p];
				end
			end
			CMD_LOCATE: begin
				for (int i = 0; i < list_len && !r.ok; i++) begin
					if (list_mem[i] == c.value) begin
						r.ok = 1'b1;
						r.found_index = IDX_W'(i);
					end
				end
			end
			CMD_INSERT: begin
				if (list_len < LIST_DEPTH && p <= list_len) begin
					for (int i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = c.value;
					list_len++;
					r.ok = 1'b1;
				end
			end
			default: begin
				if (p < list_len) begin
					for (int i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					r.ok = 1'b1;
				end
			end
		endcase
		r.element_count = CNT_W'(list_len);
		return r;
	endfunction

	// queue a command and track the list it leaves behind
	task automatic add_item(cmd_t command, int position, logic [VAL_W-1:0] value);
		list_cmd_t c;
		c.command = command;
		c.position = POS_W'(position);
		c.value = value;
		pending_cmds.push_back(c);
		if (command == CMD_INSERT && plan_list.size() < LIST_DEPTH &&
				position <= plan_list.size())
			plan_list.insert(position, value);
		else if (command == CMD_DELETE && position < plan_list.size())
			plan_list.delete(position);
	endtask

	// element values: extremes, a small pool for duplicates, or anything
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return VAL_W'($urandom_range(0, 7));
			default: return $urandom();
		endcase
	endfunction

	// locate keys mostly hit an element already in the list
	function automatic logic [VAL_W-1:0] pick_key();
		if (plan_list.size() != 0 && $urandom_range(0, 99) < 60)
			return plan_list[$urandom_range(0, plan_list.size() - 1)];
		return pick_value();
	endfunction

	// idle rates per phase of the run
	always_comb begin
		if (cmd_taken * 3 < item_total) begin
			tx_idle_pct = 37;
			rx_idle_pct = 51;
		end else if (cmd_taken * 3 < item_total * 2) begin
			tx_idle_pct = 51;
			rx_idle_pct = 37;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	end

	// command driver, predicts each item as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.command <= CMD_GET;
			cmd_bus.position <= '0;
			cmd_bus.value <= '0;
		end else if (!cmd_bus.valid || cmd_bus.ready) begin
			if (cmd_bus.valid) begin
				owed_results.push_back(apply_list_command('{cmd_t'(cmd_bus.command),
					cmd_bus.position, cmd_bus.value}));
				cmd_taken <= cmd_taken + 1;
			end
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				next_cmd = pending_cmds.pop_front();
				cmd_bus.valid <= 1'b1;
				cmd_bus.command <= next_cmd.command;
				cmd_bus.position <= next_cmd.position;
				cmd_bus.value <= next_cmd.value;
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_bus.ready <= 1'b0;
		else
			rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: ok=%0b read_value=%h found_index=%0d count=%0d",
					$time, rsp_bus.ok, rsp_bus.read_value, rsp_bus.found_index,
					rsp_bus.element_count);
			end else begin
				want = owed_results.pop_front();
				if (rsp_bus.ok !== want.ok) begin
					errors++;
					$display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_bus.ok);
				end
				if (rsp_bus.read_value !== want.read_value) begin
					errors++;
					$display("%0t: read_value expected %h actual %h", $time,
						want.read_value, rsp_bus.read_value);
				end
				if (rsp_bus.found_index !== want.found_index) begin
					errors++;
					$display("%0t: found_index expected %0d actual %0d", $time,
						want.found_index, rsp_bus.found_index);
				end
				if (rsp_bus.element_count !== want.element_count) begin
					errors++;
					$display("%0t: element_count expected %0d actual %0d", $time,
						want.element_count, rsp_bus.element_count);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin
		int  n;
		int  roll;
		int  pos;
		bit  filling;
		cmd_t op;

		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_GET;
		cmd_bus.position = '0;
		cmd_bus.value = '0;
		rsp_bus.ready = 1'b0;
		arst_n = 1'b0;

		// empty list: every access rejected, insert past the end rejected
		add_item(CMD_GET, 0, 32'h0);
		add_item(CMD_DELETE, 0, 32'h0);
		add_item(CMD_LOCATE, 0, 32'd12345);
		add_item(CMD_INSERT, 1, 32'h1111_1111);
		// build 0, -1, -1, min, max through append, front and middle inserts
		add_item(CMD_INSERT, 0, 32'h8000_0000);
		add_item(CMD_INSERT, 1, 32'h7fff_ffff);
		add_item(CMD_INSERT, 0, 32'h0000_0000);
		add_item(CMD_INSERT, 1, 32'hffff_ffff);
		add_item(CMD_INSERT, 2, 32'hffff_ffff);
		// duplicate key reports the first match, absent key misses
		add_item(CMD_LOCATE, 127, 32'hffff_ffff);
		add_item(CMD_LOCATE, 0, 32'h7fff_ffff);
		add_item(CMD_LOCATE, 0, 32'h0000_0005);
		// reads at both ends and out of range
		add_item(CMD_GET, 4, 32'hffff_ffff);
		add_item(CMD_GET, 0, 32'h0);
		add_item(CMD_GET, 5, 32'h0);
		add_item(CMD_GET, 64, 32'h0);
		add_item(CMD_INSERT, 64, 32'h5a5a_5a5a);
		// delete last, then first, then out of range
		add_item(CMD_DELETE, 4, 32'h0);
		add_item(CMD_DELETE, 0, 32'h0);
		add_item(CMD_DELETE, 3, 32'h0);
		add_item(CMD_DELETE, 64, 32'h0);
		add_item(CMD_LOCATE, 0, 32'h0000_0000);

		// random part: sweep the list between empty and full repeatedly
		filling = 1'b1;
		while (pending_cmds.size() < ITEM_TARGET) begin
			n = plan_list.size();
			if (filling && n == LIST_DEPTH) begin
				// full list: last slot lookup and a rejected insert
				add_item(CMD_LOCATE, 0, plan_list[LIST_DEPTH-1]);
				add_item(CMD_GET, LIST_DEPTH - 1, pick_value());
				add_item(CMD_INSERT, $urandom_range(0, LIST_DEPTH), pick_value());
				filling = 1'b0;
			end else if (!filling && n == 0) begin
				filling = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 15)
				op = CMD_GET;
			else if (roll < 25)
				op = CMD_LOCATE;
			else if (roll < (filling ? 85 : 40))
				op = CMD_INSERT;
			else
				op = CMD_DELETE;
			if ($urandom_range(0, 99) < 12)
				pos = $urandom_range(0, LIST_DEPTH);
			else if (op == CMD_INSERT)
				pos = $urandom_range(0, n);
			else
				pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
			add_item(op, pos, (op == CMD_LOCATE) ? pick_key() : pick_value());
		end
		item_total = pending_cmds.size();

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_cmds.size() != 0 || cmd_bus.valid)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: ordered_array_list_engine.f
+incdir+src
src/oal_pkg.sv
src/oal_cmd_if.sv
src/oal_rsp_if.sv
src/oal_ram.sv
src/oal_ctrl.sv
src/oal_datapath.sv
src/ordered_array_list_engine.sv
src/oal_checker.sv
sim/tb_top.sv
